// ----- src/bmhq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes for the binary max-heap queue
// Request and response item layouts, operation codes, status codes and the
// sentinel key used for empty reads and fresh leaves.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	// Operation codes carried in req.func
	localparam logic [1:0] FUNC_INSERT   = 2'd0;
	localparam logic [1:0] FUNC_EXTRACT  = 2'd1;
	localparam logic [1:0] FUNC_INCREASE = 2'd2;

	// Status codes returned in rsp.status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_REJECT   = 2'd3;

	// Key written into a new leaf and returned when nothing is extracted
	localparam logic signed [31:0] SENTINEL_KEY = -32'sd100000;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] key;
		logic [9:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic [10:0]        occupancy;
	} rsp_t;

endpackage

// ----- src/bmhq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- src/binary_max_heap_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue: priority queue of signed 32-bit keys
// Array-based binary max-heap held in one synchronous RAM, with insert,
// extract-max and increase-key operations.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one operation item; rsp
//   channel (rsp_valid/rsp_ready/rsp) returns exactly one result item for it.
//   One item is worked on at a time; req_ready is high whenever the engine
//   is idle, even while the previous result still sits in the output
//   register waiting for rsp_ready. The next item can be taken in the cycle
//   after a result is loaded.
//   Each operation walks the heap through the single RAM read port
//   (registered read), one level at a time:
//     insert       : climbs from the new leaf, reading each parent and
//                    moving it down until the parent is not smaller
//     increase-key : reads the entry, rejects a smaller key, then climbs
//     extract-max  : reads the root and the last entry, then sifts down,
//                    reading the left and right child at each level
//     full / empty / out of range / unused code / key below sentinel : no walk
//   A stalled receiver holds the result register; a finished item then
//   waits in the done state and the engine takes no new item until the
//   result register frees up.
//   Reset empties the heap (entry count to zero); RAM contents are not
//   cleared, and a location's data is never used before it is written.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 10) ? CW : 10;
	localparam int XW = AW + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EX_ROOT,
		S_EX_LAST,
		S_EX_MOVE,
		S_INC_RD,
		S_INC_CMP,
		S_UP_RD,
		S_UP_CMP,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] key_q;
	logic signed [31:0] lkey_q;
	logic               rvalid_q;
	logic signed [31:0] res_value_q;
	logic [1:0]         res_status_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               req_fire;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [31:0]        mem_rdata_raw;
	logic signed [31:0] mem_rdata;

	logic [XW-1:0]      l_w;
	logic [XW-1:0]      r_w;
	logic [XW-1:0]      count_x;
	logic [AW-1:0]      parent;
	logic               is_full;
	logic               pos_out;
	logic               load_rsp;

	logic               dn_move;
	logic               dn_right;
	logic signed [31:0] dn_best;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign mem_rdata = mem_rdata_raw;

	// child and parent indexes of the current hole
	assign l_w     = {1'b0, idx_q, 1'b1};
	assign r_w     = l_w + XW'(1);
	assign count_x = XW'(count_q);
	assign parent  = (idx_q - AW'(1)) >> 1;
	assign is_full = (count_q >= CW'(CAPACITY));
	assign pos_out = (PW'(req.position) >= PW'(count_q));
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// sift-down choice: left wins ties, a child moves only if strictly larger
	always_comb begin
		dn_best  = key_q;
		dn_move  = 1'b0;
		dn_right = 1'b0;
		if (lkey_q > dn_best) begin
			dn_best = lkey_q;
			dn_move = 1'b1;
		end
		if (rvalid_q && (mem_rdata > dn_best)) begin
			dn_best  = mem_rdata;
			dn_move  = 1'b1;
			dn_right = 1'b1;
		end
	end

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = key_q;
		mem_raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				mem_we    = req_fire && (req.func == FUNC_INSERT) && !is_full &&
				            (req.key < SENTINEL_KEY);
				mem_waddr = AW'(count_q);
				mem_wdata = SENTINEL_KEY;
			end
			S_EX_ROOT: mem_raddr = '0;
			S_EX_LAST: mem_raddr = AW'(count_q);
			S_UP_RD: begin
				mem_raddr = parent;
				mem_we    = (idx_q == '0);
			end
			S_UP_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = (mem_rdata < key_q) ? mem_rdata : key_q;
			end
			S_DN_L: begin
				mem_raddr = AW'(l_w);
				mem_we    = (l_w >= count_x);
			end
			S_DN_R: mem_raddr = AW'(r_w);
			S_DN_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = dn_best;
			end
			default: mem_we = 1'b0;
		endcase
	end

	// operation sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			key_q        <= '0;
			lkey_q       <= '0;
			rvalid_q     <= 1'b0;
			res_value_q  <= SENTINEL_KEY;
			res_status_q <= STAT_OK;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// result valid: set on load, cleared when taken
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						res_value_q  <= SENTINEL_KEY;
						res_status_q <= STAT_OK;
						key_q        <= req.key;
						idx_q        <= AW'(req.position);
						state_q      <= S_DONE;
						case (req.func)
							FUNC_INSERT: begin
								if (is_full) begin
									res_status_q <= STAT_FULL;
								end else begin
									count_q <= count_q + CW'(1);
									idx_q   <= AW'(count_q);
									if (req.key >= SENTINEL_KEY) begin
										state_q <= S_UP_RD;
									end
								end
							end
							FUNC_EXTRACT: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_EX_ROOT;
								end
							end
							FUNC_INCREASE: begin
								if (pos_out) begin
									res_status_q <= STAT_REJECT;
								end else begin
									state_q <= S_INC_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_EX_ROOT: begin
					count_q <= count_q - CW'(1);
					state_q <= S_EX_LAST;
				end
				S_EX_LAST: begin
					res_value_q <= mem_rdata;
					state_q     <= S_EX_MOVE;
				end
				S_EX_MOVE: begin
					key_q <= mem_rdata;
					idx_q <= '0;
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_L;
					end
				end
				S_INC_RD: state_q <= S_INC_CMP;
				S_INC_CMP: begin
					if (key_q < mem_rdata) begin
						res_status_q <= STAT_REJECT;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: begin
					if (idx_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (mem_rdata < key_q) begin
						idx_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DN_L: begin
					if (l_w >= count_x) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_R;
					end
				end
				S_DN_R: begin
					lkey_q   <= mem_rdata;
					rvalid_q <= (r_w < count_x);
					state_q  <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (dn_move) begin
						idx_q   <= dn_right ? AW'(r_w) : AW'(l_w);
						state_q <= S_DN_L;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_rsp) begin
						rsp_q.value     <= res_value_q;
						rsp_q.status    <= res_status_q;
						rsp_q.occupancy <= 11'(count_q);
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	bmhq_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata_raw)
	);

	// the entry count never exceeds the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("heap entry count above capacity");

	// the entry count moves by at most one per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("heap entry count jumped");

	// the engine leaves idle only when an item is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && !req_fire) |=> (state_q == S_IDLE))
		else $error("engine started without an item");

	// a sift-down hole always lies inside the heap
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN_L) |-> (XW'(idx_q) < count_x))
		else $error("sift-down index beyond entry count");

	// a result is loaded only from the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result loaded outside done state");

endmodule
